### rtl/core/jsu_pkg.sv
// Shared types, codes and decode helpers for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_U0   = 3'd2,
    PH_U1   = 3'd3,
    PH_U2   = 3'd4,
    PH_U3   = 3'd5,
    PH_X0   = 3'd6,
    PH_X1   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_CLOSE = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  typedef struct packed {
    logic    has;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [1:0] count;
    status_t status;
  } step_res_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) h.val = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) h.val = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) h.val = 4'(c - 8'h37);
    else h.ok = 1'b0;
    return h;
  endfunction

  // Zero means "not a simple escape"
  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_DQUOTE: r = CH_DQUOTE;
      CH_SLASH:  r = CH_SLASH;
      CH_BSLASH: r = CH_BSLASH;
      CH_LOW_B:  r = 8'h08;
      CH_LOW_F:  r = 8'h0c;
      CH_LOW_N:  r = 8'h0a;
      CH_LOW_R:  r = 8'h0d;
      CH_LOW_T:  r = 8'h09;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic utf8_t encode_utf8(input logic [15:0] code);
    utf8_t u;
    u = '0;
    if (|code[15:11]) begin
      u.b0  = 8'hE0 | {4'd0, code[15:12]};
      u.b1  = 8'h80 | {2'd0, code[11:6]};
      u.b2  = 8'h80 | {2'd0, code[5:0]};
      u.cnt = 2'd3;
    end else if (|code[10:7]) begin
      u.b0  = 8'hC0 | {3'd0, code[10:6]};
      u.b1  = 8'h80 | {2'd0, code[5:0]};
      u.cnt = 2'd2;
    end else if (|code[6:0]) begin
      u.b0  = {1'b0, code[6:0]};
      u.cnt = 2'd1;
    end
    return u;
  endfunction

endpackage

### rtl/core/jsu_step.sv
// Escape state machine: phase and hex accumulator, decodes one byte per advance.
module jsu_step
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] char_in,
  input  logic       quote_single,
  input  logic       at_end,
  output step_res_t  res
);

  phase_t      phase_r, phase_nxt;
  logic [11:0] accum_r, accum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      accum_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
    end
  end

  logic [7:0] quote;
  logic [7:0] simple;
  hex_t       hx;
  utf8_t      u8;
  logic [7:0] xbyte;
  logic [7:0] b0, b1, b2;
  logic [1:0] n;
  status_t    st;

  assign quote  = quote_single ? CH_SQUOTE : CH_DQUOTE;
  assign simple = simple_escape(char_in);
  assign hx     = hex_value(char_in);
  assign u8     = encode_utf8({accum_r, hx.val});
  assign xbyte  = {accum_r[3:0], hx.val};

  always_comb begin
    b0        = '0;
    b1        = '0;
    b2        = '0;
    n         = 2'd0;
    st        = ST_RUN;
    phase_nxt = PH_TEXT;
    accum_nxt = accum_r;
    unique case (phase_r)
      PH_TEXT: begin
        if (char_in == quote) begin
          st = ST_CLOSE;
        end else if (char_in == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else if (char_in != 8'h00) begin
          b0 = char_in;
          n  = 2'd1;
        end
      end
      PH_ESC: begin
        if (char_in == CH_LOW_U) begin
          phase_nxt = PH_U0;
        end else if (char_in == CH_LOW_X) begin
          phase_nxt = PH_X0;
        end else if (simple != 8'h00) begin
          b0 = simple;
          n  = 2'd1;
        end else begin
          // unknown escape passes through with its backslash
          b0 = CH_BSLASH;
          b1 = char_in;
          n  = 2'd2;
        end
      end
      PH_X0, PH_X1, PH_U0, PH_U1, PH_U2, PH_U3: begin
        if (!hx.ok) begin
          st = ST_ERR;
        end else if (phase_r == PH_X0) begin
          accum_nxt = {8'd0, hx.val};
          phase_nxt = PH_X1;
        end else if (phase_r == PH_X1) begin
          b0 = xbyte;
          n  = (xbyte != 8'h00) ? 2'd1 : 2'd0;
        end else if (phase_r == PH_U3) begin
          b0 = u8.b0;
          b1 = u8.b1;
          b2 = u8.b2;
          n  = u8.cnt;
        end else begin
          accum_nxt = {accum_r[7:0], hx.val};
          phase_nxt = phase_t'(phase_r + 3'd1);
        end
      end
      default: st = ST_ERR;
    endcase

    if (at_end && st != ST_CLOSE) st = ST_ERR;
    if (st == ST_ERR) begin
      n  = 2'd0;
      b0 = '0;
      b1 = '0;
      b2 = '0;
    end
    if (st != ST_RUN) phase_nxt = PH_TEXT;
    if (phase_nxt == PH_TEXT) accum_nxt = '0;

    res.has    = (n != 2'd0) || (st != ST_RUN);
    res.byte_a = b0;
    res.byte_b = b1;
    res.byte_c = b2;
    res.count  = n;
    res.status = st;
  end

endmodule

### rtl/core/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, decode step, result register.
//
// Feed the bytes of a quoted JSON string body, after the opening quote, on
// the in_ channel with in_quote_single selecting the closing quote and
// in_at_end marking the last byte of the buffer. Each byte produces at most
// one result item on the out_ channel: up to three decoded bytes (out_count
// of them valid) and a status of in progress, closed or error. Bytes that
// only advance an escape, and dropped NUL bytes, produce no item.
// An accepted byte is held in the input register and its result item in the result
// register. One byte is accepted every cycle; the escape phase and hex accumulator
// update on each advance, so nothing limits the rate but out_stall.
// After a closing quote or an error the decoder is back in plain text, ready
// for the next string. Reset (rst_n low, synchronous) empties both
// registers and returns the decoder to plain text.
// When out_stall holds a result, a byte that yields no result still drains;
// one that yields a result waits in the input register and in_stall rises.
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_quote_single,
  input  logic       in_at_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_a,
  output logic [7:0] out_byte_b,
  output logic [7:0] out_byte_c,
  output logic [1:0] out_count,
  output logic [1:0] out_status
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] char_r;
  logic       quote_r;
  logic       end_r;
  logic       out_valid_r, out_valid_nxt;
  step_res_t  res;
  step_res_t  res_r;
  logic       fire;
  logic       take;

  jsu_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (fire),
    .char_in      (char_r),
    .quote_single (quote_r),
    .at_end       (end_r),
    .res          (res)
  );

  // item leaves the input register when its result (if any) has a slot
  assign fire     = in_valid_r && (!res.has || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take) in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (fire && res.has) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r  <= in_char_in;
      quote_r <= in_quote_single;
      end_r   <= in_at_end;
    end
    if (fire && res.has) res_r <= res;
  end

  assign out_valid  = out_valid_r;
  assign out_byte_a = res_r.byte_a;
  assign out_byte_b = res_r.byte_b;
  assign out_byte_c = res_r.byte_c;
  assign out_count  = res_r.count;
  assign out_status = res_r.status;

endmodule

### bench/json_string_unescaper_test.sv
// Self-checking testbench for json_string_unescaper: random strings, escapes and handshake idling.
module json_string_unescaper_test;
  import jsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 700;

  class unescape_tracker;
    typedef struct {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] count;
      status_t    status;
    } decoded_t;

    phase_t      phase;
    logic [11:0] hex_acc;
    decoded_t    pending_decodes[$];
    int          mismatches;
    int          bytes_in;
    int          items_out;
    int          closes;
    int          aborts;

    function new();
      phase = PH_TEXT;
      hex_acc = '0;
    endfunction

    // {ok, value}
    static function logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
      return 5'd0;
    endfunction

    function void note_byte(input logic [7:0] c, input logic qs, input logic last);
      decoded_t    d;
      phase_t      nxt;
      logic [7:0]  quote;
      logic [7:0]  e;
      logic [4:0]  h;
      logic [15:0] code;
      d = '{8'h00, 8'h00, 8'h00, 2'd0, ST_RUN};
      nxt = PH_TEXT;
      quote = qs ? CH_SQUOTE : CH_DQUOTE;
      bytes_in++;
      case (phase)
        PH_TEXT: begin
          if (c == quote) d.status = ST_CLOSE;
          else if (c == CH_BSLASH) nxt = PH_ESC;
          else if (c != 8'h00) begin
            d.byte_a = c;
            d.count = 2'd1;
          end
        end
        PH_ESC: begin
          case (c)
            CH_DQUOTE: e = CH_DQUOTE;
            CH_SLASH:  e = CH_SLASH;
            CH_BSLASH: e = CH_BSLASH;
            CH_LOW_B:  e = 8'h08;
            CH_LOW_F:  e = 8'h0c;
            CH_LOW_N:  e = 8'h0a;
            CH_LOW_R:  e = 8'h0d;
            CH_LOW_T:  e = 8'h09;
            default:   e = 8'h00;
          endcase
          if (c == CH_LOW_U) nxt = PH_U0;
          else if (c == CH_LOW_X) nxt = PH_X0;
          else if (e != 8'h00) begin
            d.byte_a = e;
            d.count = 2'd1;
          end else begin
            // unknown escape keeps its backslash, even before a NUL
            d.byte_a = CH_BSLASH;
            d.byte_b = c;
            d.count = 2'd2;
          end
        end
        default: begin
          h = nibble_of(c);
          if (!h[4]) d.status = ST_ERR;
          else if (phase == PH_X0) begin
            hex_acc = {8'h00, h[3:0]};
            nxt = PH_X1;
          end else if (phase == PH_X1) begin
            d.byte_a = {hex_acc[3:0], h[3:0]};
            d.count = (d.byte_a != 8'h00) ? 2'd1 : 2'd0;
          end else if (phase == PH_U3) begin
            code = {hex_acc, h[3:0]};
            if (code >= 16'h0800) begin
              d.byte_a = {4'hE, code[15:12]};
              d.byte_b = {2'b10, code[11:6]};
              d.byte_c = {2'b10, code[5:0]};
              d.count = 2'd3;
            end else if (code >= 16'h0080) begin
              d.byte_a = {3'b110, code[10:6]};
              d.byte_b = {2'b10, code[5:0]};
              d.count = 2'd2;
            end else if (code != 16'h0000) begin
              d.byte_a = {1'b0, code[6:0]};
              d.count = 2'd1;
            end
          end else begin
            hex_acc = {hex_acc[7:0], h[3:0]};
            nxt = phase_t'(phase + 3'd1);
          end
        end
      endcase
      if (last && d.status != ST_CLOSE) d.status = ST_ERR;
      if (d.status == ST_ERR) d = '{8'h00, 8'h00, 8'h00, 2'd0, ST_ERR};
      if (d.status != ST_RUN) nxt = PH_TEXT;
      if (nxt == PH_TEXT) hex_acc = '0;
      phase = nxt;
      if (d.status == ST_CLOSE) closes++;
      if (d.status == ST_ERR) aborts++;
      if (d.count != 2'd0 || d.status != ST_RUN) pending_decodes.push_back(d);
    endfunction

    task report(input string what, input logic [7:0] got, input logic [7:0] want);
      if (mismatches < 25)
        $display("MISMATCH item %0d %s: got %02h expected %02h", items_out, what, got, want);
      mismatches++;
    endtask

    task check_decode(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                      input logic [1:0] cnt, input logic [1:0] st);
      decoded_t w;
      items_out++;
      if (pending_decodes.size() == 0) begin
        report("item with nothing expected", a, 8'h00);
        return;
      end
      w = pending_decodes.pop_front();
      if (a !== w.byte_a) report("byte_a", a, w.byte_a);
      if (b !== w.byte_b) report("byte_b", b, w.byte_b);
      if (c !== w.byte_c) report("byte_c", c, w.byte_c);
      if (cnt !== w.count) report("count", {6'd0, cnt}, {6'd0, w.count});
      if (st !== w.status) report("status", {6'd0, st}, {6'd0, w.status});
    endtask
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_quote_single = 1'b0;
  logic       in_at_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_a;
  logic [7:0] out_byte_b;
  logic [7:0] out_byte_c;
  logic [1:0] out_count;
  logic [1:0] out_status;

  unescape_tracker tracker = new();
  int   items_sent = 0;
  int   strings_sent = 0;
  int   idle_cycles = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  logic cur_qs;
  bit   aborted;

  json_string_unescaper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_quote_single (in_quote_single),
    .in_at_end       (in_at_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_a      (out_byte_a),
    .out_byte_b      (out_byte_b),
    .out_byte_c      (out_byte_c),
    .out_count       (out_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Handshakes are sampled with pre-edge values; inputs are noted before results are checked.
  always @(posedge clk) begin
    bit took;
    took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_byte(in_char_in, in_quote_single, in_at_end);
        took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        tracker.check_decode(out_byte_a, out_byte_b, out_byte_c, out_count, out_status);
        took = 1'b1;
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles with no handshake", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: a random hold before each item, with quiet stretches.
  initial begin
    int hold;
    int served;
    served = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (served % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      hold = rx_quiet ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      served++;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic qs, input logic e);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_quote_single <= qs;
    in_at_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_decodes.size() != 0) @(posedge clk);
  endtask

  // A rare early buffer end turns any byte of the string into its last.
  task automatic emit(input logic [7:0] c);
    logic e;
    if (!aborted) begin
      e = ($urandom_range(0, 149) == 0);
      send_byte(c, cur_qs, e);
      aborted = e;
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return (upper ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  task automatic emit_hex(input logic [15:0] v, input int digits);
    for (int i = digits - 1; i >= 0; i--)
      emit(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
  endtask

  task automatic send_string();
    int          kind;
    int          k;
    logic [7:0]  c;
    logic [7:0]  quote;
    logic [15:0] v;
    logic [7:0]  simple_set[8];
    logic [15:0] edge_codes[7];
    simple_set = '{CH_DQUOTE, CH_SLASH, CH_BSLASH, CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R,
                   CH_LOW_T};
    edge_codes = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD800};
    cur_qs = 1'($urandom_range(0, 1));
    quote = cur_qs ? CH_SQUOTE : CH_DQUOTE;
    aborted = 1'b0;
    tx_quiet = ($urandom_range(0, 3) == 0);
    strings_sent++;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes, any quote select, occasional buffer end
      repeat ($urandom_range(1, 20))
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7) == 0);
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      if (aborted) break;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        c = 8'($urandom_range(0, 255));
        if (c == quote || c == CH_BSLASH) c = c ^ 8'h01;
        emit(c);
      end else if (kind < 55) begin
        emit(CH_BSLASH);
        emit(simple_set[$urandom_range(0, 7)]);
      end else if (kind < 62) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_LOW_U || c == CH_LOW_X) c = CH_SQUOTE;
        emit(CH_BSLASH);
        emit(c);
      end else if (kind < 82) begin
        case ($urandom_range(0, 3))
          0: v = 16'($urandom_range(16'h0000, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          2: v = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: v = edge_codes[$urandom_range(0, 6)];
        endcase
        emit(CH_BSLASH);
        emit(CH_LOW_U);
        emit_hex(v, 4);
      end else if (kind < 94) begin
        v = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 255));
        emit(CH_BSLASH);
        emit(CH_LOW_X);
        emit_hex(v, 2);
      end else begin
        // broken hex escape: some digits, then a non-hex byte
        emit(CH_BSLASH);
        if ($urandom_range(0, 1)) begin
          emit(CH_LOW_U);
          k = $urandom_range(0, 3);
        end else begin
          emit(CH_LOW_X);
          k = $urandom_range(0, 1);
        end
        emit_hex(16'($urandom_range(0, 16'hFFFF)), k);
        c = 8'($urandom_range(0, 255));
        if (unescape_tracker::nibble_of(c) >= 5'h10) c = 8'h67;
        emit(c);
        aborted = 1'b1;
      end
    end
    if (!aborted) send_byte(quote, cur_qs, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);      // NUL dropped
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0);
    send_byte(CH_LOW_N, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b1, 1'b0);  // escaped double quote inside a single-quoted string
    send_byte(CH_DQUOTE, 1'b1, 1'b0);
    send_byte(CH_BSLASH, 1'b1, 1'b0);  // escaped single quote is unknown: 5C 27
    send_byte(CH_SQUOTE, 1'b1, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0);
    send_byte(CH_LOW_U, 1'b0, 1'b0);
    send_byte(8'h46, 1'b0, 1'b0);
    send_byte(8'h66, 1'b0, 1'b0);
    send_byte(8'h46, 1'b0, 1'b0);
    send_byte(8'h66, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0);  // \x00 dropped
    send_byte(CH_LOW_X, 1'b0, 1'b0);
    send_byte(8'h30, 1'b0, 1'b0);
    send_byte(8'h30, 1'b0, 1'b0);
    send_byte(CH_BSLASH, 1'b0, 1'b0);  // bad hex digit
    send_byte(CH_LOW_X, 1'b0, 1'b0);
    send_byte(8'h67, 1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0);
    send_byte(CH_SQUOTE, 1'b1, 1'b1);  // close on the last byte
    send_byte(CH_BSLASH, 1'b0, 1'b1);  // trailing backslash at buffer end
    drain();

    while (items_sent < RANDOM_ITEMS + 25) begin
      send_string();
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d random strings; %0d result items checked",
             tracker.bytes_in, strings_sent, tracker.items_out);
    $display("Strings closed: %0d, error ends: %0d, mismatches: %0d",
             tracker.closes, tracker.aborts, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_step.sv
rtl/core/json_string_unescaper.sv
bench/json_string_unescaper_test.sv
